// ===== sv/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned MaxBlocksDef   = 64;
  localparam int unsigned HeaderBytesDef = 12;
  // Alignment is fixed; rounding is a mask
  localparam int unsigned AlignBytes     = 8;

  typedef enum logic [1:0] {
    OpAlloc  = 2'd0,
    OpFree   = 2'd1,
    OpResize = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StDone    = 2'd0,
    StNoFit   = 2'd1,
    StNothing = 2'd2,
    StUnknown = 2'd3
  } status_e;

  typedef enum logic {
    CfgHeapBase  = 1'b0,
    CfgHeapBytes = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    SIdle, SFindRd, SFindChk, SFitRd, SFitChk, SShRd, SShWr,
    SSplitWr, SGrabWr, SMrgRd, SMrgChk, SDone
  } fsm_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] block_address;
    logic [31:0] request_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_address;
    logic [31:0] copy_source;
    logic [31:0] copy_bytes;
  } rsp_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        free;
  } entry_t;

endpackage

// ===== sv/ffha_table.sv =====
// ----------------------------------------------------------------------------
// ffha_table
// Block table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_table #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  ffha_pkg::entry_t wdata_i,
  input  logic [IdxW-1:0]  raddr_i,
  output ffha_pkg::entry_t rdata_o
);
  import ffha_pkg::*;

  entry_t mem_q [Depth];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one entry; the read data is registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/first_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit allocator over an address-ordered block table with coalescing.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; its result shows
// on rsp_o for one cycle with done_o and must be taken then. The table lives
// in one memory, each entry visited by a read state and a check state: a find
// or fit scan walks the N blocks in use, a split shifts the blocks above the fit
// one by one, and a free, a resize to zero bytes or a moving resize adds a merge
// pass over the table. Writing either heap register resets the table to one
// free block at once.
module first_fit_heap_allocator_unit #(
  parameter int unsigned MaxBlocks   = ffha_pkg::MaxBlocksDef,
  parameter int unsigned HeaderBytes = ffha_pkg::HeaderBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ffha_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            done_o,
  output ffha_pkg::rsp_t  rsp_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [31:0]     cfg_wdata_i
);
  import ffha_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxBlocks);
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);
  localparam logic [31:0] Hdr  = 32'(HeaderBytes);
  localparam logic [32:0] AMsk = 33'(AlignBytes - 1);

  fsm_e state_q, state_d;
  logic [31:0] base_q, bytes_q;
  logic        fresh_q;
  logic [CntW-1:0] cnt_q, cnt_d, idx_q, idx_d, w_q, w_d, fit_q, fit_d;
  logic [1:0]  op_q, op_d;
  logic [31:0] addr_q, addr_d, mark_q, mark_d, osize_q, osize_d;
  logic [32:0] need_q, need_d;
  logic        zero_q, zero_d, mv_q, mv_d, split_q, split_d, marked_q, marked_d;
  entry_t      fe_q, fe_d, prev_q, prev_d;
  rsp_t        rsp_q, rsp_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, mem_rd, rd, init_e;

  ffha_table #(.Depth(MaxBlocks), .IdxW(IdxW)) u_table (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(mem_rd)
  );

  // Entry zero reads as the initial block until first written
  always_comb begin
    init_e.offset = '0;
    init_e.size   = (bytes_q >= Hdr) ? bytes_q - Hdr : '0;
    init_e.free   = 1'b1;
  end
  assign rd = (fresh_q && idx_q == '0) ? init_e : mem_rd;

  // Shared conditions
  logic        scan_end, hit, fits, can_split, sh_more;
  logic [32:0] need_in;
  logic [31:0] pay;
  entry_t      me;
  assign need_in   = ({1'b0, req_i.request_bytes} + AMsk) & ~AMsk;
  assign scan_end  = (idx_q == cnt_q);
  assign pay       = base_q + rd.offset + Hdr;
  assign hit       = (pay == addr_q);
  assign fits      = rd.free && ({1'b0, rd.size} >= need_q);
  assign can_split = ({2'b0, rd.size} > {1'b0, need_q} + 34'(HeaderBytes)) &&
                     (cnt_q < CntW'(MaxBlocks));
  assign sh_more   = ((idx_q - 1'b1) > (fit_q + 1'b1));
  always_comb begin
    me = rd;
    if (!marked_q && rd.offset == mark_q) me.free = 1'b1;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          priority case (op_e'(req_i.opcode))
            OpAlloc:  state_d = (req_i.request_bytes == '0) ? SDone : SFitRd;
            OpFree:   state_d = (req_i.block_address == '0) ? SDone : SFindRd;
            OpResize: begin
              if (req_i.block_address != '0) state_d = SFindRd;
              else state_d = (req_i.request_bytes == '0) ? SDone : SFitRd;
            end
            default:  state_d = SDone;
          endcase
        end
      end
      SFindRd:  state_d = scan_end ? SDone : SFindChk;
      SFindChk: begin
        if (!hit) state_d = SFindRd;
        else if (op_q == OpFree || zero_q) state_d = SMrgRd;
        else if ({1'b0, rd.size} >= need_q) state_d = SDone;
        else state_d = SFitRd;
      end
      SFitRd:   state_d = scan_end ? SDone : SFitChk;
      SFitChk: begin
        if (!fits) state_d = SFitRd;
        else if (!can_split) state_d = SGrabWr;
        else if (cnt_q > idx_q + 1'b1) state_d = SShRd;
        else state_d = SSplitWr;
      end
      SShRd:    state_d = SShWr;
      SShWr:    state_d = sh_more ? SShRd : SSplitWr;
      SSplitWr: state_d = SGrabWr;
      SGrabWr:  state_d = mv_q ? SMrgRd : SDone;
      SMrgRd:   state_d = scan_end ? SDone : SMrgChk;
      SMrgChk:  state_d = SMrgRd;
      SDone:    state_d = SIdle;
      default:  state_d = SIdle;
    endcase
  end

  // Datapath and table access
  always_comb begin
    cnt_d = cnt_q; idx_d = idx_q; w_d = w_q; fit_d = fit_q;
    op_d = op_q; addr_d = addr_q; mark_d = mark_q; osize_d = osize_q;
    need_d = need_q; zero_d = zero_q; mv_d = mv_q; split_d = split_q;
    marked_d = marked_q; fe_d = fe_q; prev_d = prev_q; rsp_d = rsp_q;
    we = 1'b0; waddr = idx_q[IdxW-1:0]; wdata = rd;
    raddr = idx_q[IdxW-1:0];
    unique case (state_q)
      SIdle: begin
        op_d = req_i.opcode; addr_d = req_i.block_address;
        need_d = need_in; zero_d = (req_i.request_bytes == '0);
        mv_d = 1'b0; idx_d = '0; w_d = '0; marked_d = 1'b0;
        rsp_d = '0;
        if (start_i) begin
          if (req_i.opcode == OpNone || req_i.request_bytes == '0 &&
              (req_i.opcode == OpAlloc ||
               (req_i.opcode == OpResize && req_i.block_address == '0)) ||
              (req_i.opcode == OpFree && req_i.block_address == '0)) begin
            rsp_d.status = StNothing;
          end
        end
      end
      SFindRd: if (scan_end) rsp_d.status = StUnknown;
      SFindChk: begin
        if (!hit) idx_d = idx_q + 1'b1;
        else begin
          idx_d = '0; mark_d = rd.offset; osize_d = rd.size;
          if (!(op_q == OpFree || zero_q) && {1'b0, rd.size} >= need_q) begin
            rsp_d.result_address = addr_q;
          end else if (!(op_q == OpFree || zero_q)) begin
            mv_d = 1'b1;
          end
        end
      end
      SFitRd: if (scan_end) rsp_d.status = StNoFit;
      SFitChk: begin
        if (!fits) idx_d = idx_q + 1'b1;
        else begin
          fit_d = idx_q; fe_d = rd; split_d = can_split;
          rsp_d.result_address = pay;
          idx_d = cnt_q;
        end
      end
      // Move one entry up by one place
      SShRd: raddr = IdxW'(idx_q - 1'b1);
      SShWr: begin
        we = 1'b1; wdata = mem_rd;
        idx_d = idx_q - 1'b1;
      end
      SSplitWr: begin
        we = 1'b1; waddr = IdxW'(fit_q + 1'b1);
        wdata.offset = fe_q.offset + Hdr + need_q[31:0];
        wdata.size   = fe_q.size - need_q[31:0] - Hdr;
        wdata.free   = 1'b1;
        cnt_d = cnt_q + 1'b1;
      end
      SGrabWr: begin
        we = 1'b1; waddr = fit_q[IdxW-1:0];
        wdata.offset = fe_q.offset;
        wdata.size   = split_q ? need_q[31:0] : fe_q.size;
        wdata.free   = 1'b0;
        idx_d = '0;
        if (mv_q) begin
          rsp_d.copy_source = addr_q;
          rsp_d.copy_bytes  = osize_q;
        end
      end
      SMrgRd: if (scan_end) cnt_d = w_q;
      // Fold or compact one entry
      SMrgChk: begin
        we = 1'b1; idx_d = idx_q + 1'b1;
        if (me.offset == mark_q) marked_d = 1'b1;
        if (w_q != '0 && prev_q.free && me.free) begin
          prev_d.size = prev_q.size + Hdr + me.size;
          waddr = IdxW'(w_q - 1'b1); wdata = prev_d;
        end else begin
          waddr = w_q[IdxW-1:0]; wdata = me;
          prev_d = me; w_d = w_q + 1'b1;
        end
      end
      SDone: ;
      default: ;
    endcase
  end

  // Outputs
  assign busy_o = (state_q != SIdle);
  assign done_o = (state_q == SDone);
  assign rsp_o  = rsp_q;

  // Control state and heap registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; base_q <= '0; bytes_q <= 32'd65536;
      fresh_q <= 1'b1; cnt_q <= CntW'(1); idx_q <= '0; w_q <= '0;
      mv_q <= 1'b0; marked_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; w_q <= w_d;
      mv_q <= mv_d; marked_q <= marked_d;
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_idx_i) == CfgHeapBase) base_q <= cfg_wdata_i;
        else bytes_q <= cfg_wdata_i;
        fresh_q <= 1'b1;
        cnt_q   <= CntW'(1);
      end else begin
        cnt_q <= cnt_d;
        if (we && waddr == '0) fresh_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fit_q <= fit_d; op_q <= op_d; addr_q <= addr_d; mark_q <= mark_d;
    osize_q <= osize_d; need_q <= need_d; zero_q <= zero_d;
    split_q <= split_d; fe_q <= fe_d; prev_q <= prev_d; rsp_q <= rsp_d;
  end

endmodule
